FILE: hdl/blca_pkg.sv
`default_nettype none

package blca_pkg;

  localparam int NODES     = 1024;
  localparam int LEVELS    = 10;
  localparam int NODE_W    = 10;
  localparam int DEPTH_W   = 11;
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int TBL_DEPTH = NODES * LEVELS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int PC_W      = 5;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [TBL_AW-1:0]  taddr_t;
  typedef logic [PC_W-1:0]    pc_t;

  // Datapath operation of one microcode step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_ARD,
    OP_AW0,
    OP_ARDT,
    OP_AWN,
    OP_QRD,
    OP_QCMP,
    OP_LRD,
    OP_LUP,
    OP_DRD,
    OP_DST,
    OP_ERD,
    OP_EUP,
    OP_FRD,
    OP_OUTT,
    OP_OUTX
  } op_t;

  // Branch condition of one microcode step
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_DISPATCH,
    C_CLR_MORE,
    C_XZERO,
    C_ALVL_MORE,
    C_LVL_MORE,
    C_XEQY,
    C_LVL_NZ
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucw_t;

  // Step addresses of the program
  localparam pc_t S_CLEAR = 5'd0;
  localparam pc_t S_IDLE  = 5'd1;
  localparam pc_t S_ARD   = 5'd2;
  localparam pc_t S_AW0   = 5'd3;
  localparam pc_t S_ARDT  = 5'd4;
  localparam pc_t S_AWN   = 5'd5;
  localparam pc_t S_ADONE = 5'd6;
  localparam pc_t S_QRD   = 5'd7;
  localparam pc_t S_QCMP  = 5'd8;
  localparam pc_t S_LRD   = 5'd9;
  localparam pc_t S_LUP   = 5'd10;
  localparam pc_t S_DRD   = 5'd11;
  localparam pc_t S_DST   = 5'd12;
  localparam pc_t S_ERD   = 5'd13;
  localparam pc_t S_EUP   = 5'd14;
  localparam pc_t S_FRD   = 5'd15;
  localparam pc_t S_OUTT  = 5'd16;
  localparam pc_t S_OUTX  = 5'd17;

  // Request from the sequencer to the stores
  typedef struct packed {
    logic   clr;
    taddr_t clr_addr;
    logic   tbl_we;
    node_t  tbl_w_node;
    lvl_t   tbl_w_lvl;
    node_t  tbl_w_data;
    node_t  tbl_ra_node;
    lvl_t   tbl_ra_lvl;
    node_t  tbl_rb_node;
    lvl_t   tbl_rb_lvl;
    logic   dep_we;
    node_t  dep_w_node;
    depth_t dep_w_data;
    node_t  dep_ra_node;
    node_t  dep_rb_node;
  } store_req_t;

  function automatic ucw_t ucode(input pc_t pc);
    ucw_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    unique case (pc)
      S_CLEAR: w = '{op: OP_CLEAR, cond: C_CLR_MORE,  target: S_CLEAR};
      S_IDLE:  w = '{op: OP_NOP,   cond: C_DISPATCH,  target: S_QRD};
      S_ARD:   w = '{op: OP_ARD,   cond: C_XZERO,     target: S_IDLE};
      S_AW0:   w = '{op: OP_AW0,   cond: C_NEXT,      target: S_IDLE};
      S_ARDT:  w = '{op: OP_ARDT,  cond: C_NEXT,      target: S_IDLE};
      S_AWN:   w = '{op: OP_AWN,   cond: C_ALVL_MORE, target: S_ARDT};
      S_ADONE: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_IDLE};
      S_QRD:   w = '{op: OP_QRD,   cond: C_NEXT,      target: S_IDLE};
      S_QCMP:  w = '{op: OP_QCMP,  cond: C_NEXT,      target: S_IDLE};
      S_LRD:   w = '{op: OP_LRD,   cond: C_NEXT,      target: S_IDLE};
      S_LUP:   w = '{op: OP_LUP,   cond: C_LVL_MORE,  target: S_LRD};
      S_DRD:   w = '{op: OP_DRD,   cond: C_XEQY,      target: S_OUTX};
      S_DST:   w = '{op: OP_DST,   cond: C_NEXT,      target: S_IDLE};
      S_ERD:   w = '{op: OP_ERD,   cond: C_NEXT,      target: S_IDLE};
      S_EUP:   w = '{op: OP_EUP,   cond: C_LVL_NZ,    target: S_ERD};
      S_FRD:   w = '{op: OP_FRD,   cond: C_NEXT,      target: S_IDLE};
      S_OUTT:  w = '{op: OP_OUTT,  cond: C_ALWAYS,    target: S_IDLE};
      S_OUTX:  w = '{op: OP_OUTX,  cond: C_ALWAYS,    target: S_IDLE};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

  function automatic taddr_t tbl_addr(input node_t n, input lvl_t l);
    return taddr_t'(n) * taddr_t'(LEVELS) + taddr_t'(l);
  endfunction

  // Smallest level whose span covers the depth, clamped to the top level
  function automatic lvl_t start_level(input depth_t d);
    lvl_t s;
    s = '0;
    for (int k = 0; k < LEVELS - 1; k++) begin
      if ((depth_t'(1) << k) < d) begin
        s = lvl_t'(k + 1);
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/binary_lifting_lca_engine_top.sv
// Lowest-common-ancestor engine over a rooted forest, binary lifting.
// Command channel: drive action, node_a and node_b with start high; the
// transfer happens at the rising edge where start is high and busy is low.
// action 0 attaches node_a under parent node_b (0 makes a root); action 1
// queries the lowest common ancestor of node_a and node_b.
// Result channel: a query returns ancestor with done high for exactly one
// cycle; the receiver cannot stall it, so sample it on that edge. An attach
// returns nothing.
// Sequence: an attach of node 0 writes nothing. A query returns directly when
// the nodes meet after lifting, else it first descends from L, the start level
// of the descent (0 to 9). done rises in the same cycle that busy falls. The
// step order is set by the microcode program: every lift and descent level is
// one table read followed by one update step, with one read port per walking
// node.
// Reset: rst is synchronous. After it, a clearing pass zeroes the ancestor
// table and the depth store, one entry per cycle across all 10240 table
// entries, with busy held high; no command is taken until it ends.
// Control is a read-only microcode table in the package: each step drives
// the datapath below and picks the next step through a branch condition.

`default_nettype none

module binary_lifting_lca_engine_top import blca_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output      logic  busy,
  input  wire logic  action,
  input  wire node_t node_a,
  input  wire node_t node_b,
  output      logic  done,
  output      node_t ancestor
);

  // Sequencer and datapath registers
  pc_t       pc, pc_next;
  lvl_t      lvl, lvl_next;
  node_t     xr, xr_next;
  node_t     yr, yr_next;
  logic [LEVELS-1:0] gap, gap_next;
  logic      liftx, liftx_next;
  taddr_t    clr_addr, clr_addr_next;
  logic      done_next;
  node_t     ancestor_next;

  ucw_t       uw;
  store_req_t req;
  node_t      tbl_qa, tbl_qb;
  depth_t     dep_qa, dep_qb;
  depth_t     diff_ab, diff_ba;
  logic       accept;

  blca_store u_store (
    .clk    (clk),
    .req    (req),
    .tbl_qa (tbl_qa),
    .tbl_qb (tbl_qb),
    .dep_qa (dep_qa),
    .dep_qb (dep_qb)
  );

  assign uw     = ucode(pc);
  assign busy   = (pc != S_IDLE);
  assign accept = start & ~busy;

  assign diff_ab = dep_qa - dep_qb;
  assign diff_ba = dep_qb - dep_qa;

  // Datapath: each step's operation
  always_comb begin
    req           = '0;
    lvl_next      = lvl;
    xr_next       = xr;
    yr_next       = yr;
    gap_next      = gap;
    liftx_next    = liftx;
    clr_addr_next = clr_addr;
    done_next     = 1'b0;
    ancestor_next = ancestor;

    // Capture a command on transfer
    if (accept) begin
      xr_next = node_a;
      yr_next = node_b;
    end

    unique case (uw.op)
      OP_NOP: begin
      end
      OP_CLEAR: begin
        req.clr       = 1'b1;
        req.clr_addr  = clr_addr;
        clr_addr_next = clr_addr + taddr_t'(1);
      end
      OP_ARD: begin
        // Fetch the parent's depth
        req.dep_ra_node = yr;
      end
      OP_AW0: begin
        // Depth saturates at all ones; level 0 is the parent itself
        req.dep_we     = 1'b1;
        req.dep_w_node = xr;
        req.dep_w_data = (&dep_qa) ? dep_qa : dep_qa + depth_t'(1);
        req.tbl_we     = 1'b1;
        req.tbl_w_node = xr;
        req.tbl_w_lvl  = '0;
        req.tbl_w_data = yr;
        lvl_next       = '0;
      end
      OP_ARDT: begin
        req.tbl_ra_node = yr;
        req.tbl_ra_lvl  = lvl;
      end
      OP_AWN: begin
        // Chain: next level is the level-lvl ancestor of the current one
        req.tbl_we     = 1'b1;
        req.tbl_w_node = xr;
        req.tbl_w_lvl  = lvl + lvl_t'(1);
        req.tbl_w_data = tbl_qa;
        yr_next        = tbl_qa;
        lvl_next       = lvl + lvl_t'(1);
      end
      OP_QRD: begin
        req.dep_ra_node = xr;
        req.dep_rb_node = yr;
      end
      OP_QCMP: begin
        // Lift whichever node is deeper by the depth difference
        liftx_next = (dep_qa > dep_qb);
        gap_next   = (dep_qa > dep_qb) ? diff_ab[LEVELS-1:0] : diff_ba[LEVELS-1:0];
        lvl_next   = '0;
      end
      OP_LRD: begin
        req.tbl_ra_node = liftx ? xr : yr;
        req.tbl_ra_lvl  = lvl;
      end
      OP_LUP: begin
        if (gap[lvl]) begin
          if (liftx) begin
            xr_next = tbl_qa;
          end else begin
            yr_next = tbl_qa;
          end
        end
        lvl_next = lvl + lvl_t'(1);
      end
      OP_DRD: begin
        req.dep_ra_node = xr;
      end
      OP_DST: begin
        lvl_next = start_level(dep_qa);
      end
      OP_ERD: begin
        req.tbl_ra_node = xr;
        req.tbl_ra_lvl  = lvl;
        req.tbl_rb_node = yr;
        req.tbl_rb_lvl  = lvl;
      end
      OP_EUP: begin
        // Advance both nodes only while their ancestors still differ
        if (tbl_qa != tbl_qb) begin
          xr_next = tbl_qa;
          yr_next = tbl_qb;
        end
        if (lvl != '0) begin
          lvl_next = lvl - lvl_t'(1);
        end
      end
      OP_FRD: begin
        req.tbl_ra_node = xr;
        req.tbl_ra_lvl  = '0;
      end
      OP_OUTT: begin
        done_next     = 1'b1;
        ancestor_next = tbl_qa;
      end
      OP_OUTX: begin
        done_next     = 1'b1;
        ancestor_next = xr;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: next step
  always_comb begin
    pc_next = pc + pc_t'(1);
    unique case (uw.cond)
      C_NEXT:      pc_next = pc + pc_t'(1);
      C_ALWAYS:    pc_next = uw.target;
      C_DISPATCH: begin
        if (!start) begin
          pc_next = pc;
        end else if (action) begin
          pc_next = uw.target;
        end else begin
          pc_next = pc + pc_t'(1);
        end
      end
      C_CLR_MORE:  pc_next = (clr_addr != taddr_t'(TBL_DEPTH - 1)) ? uw.target
                                                                    : pc + pc_t'(1);
      C_XZERO:     pc_next = (xr == '0) ? uw.target : pc + pc_t'(1);
      C_ALVL_MORE: pc_next = (({1'b0, lvl} + (LVL_W+1)'(2)) < (LVL_W+1)'(LEVELS))
                             ? uw.target : pc + pc_t'(1);
      C_LVL_MORE:  pc_next = (({1'b0, lvl} + (LVL_W+1)'(1)) < (LVL_W+1)'(LEVELS))
                             ? uw.target : pc + pc_t'(1);
      C_XEQY:      pc_next = (xr == yr) ? uw.target : pc + pc_t'(1);
      C_LVL_NZ:    pc_next = (lvl != '0) ? uw.target : pc + pc_t'(1);
      default:     pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      lvl      <= '0;
    end else begin
      pc       <= pc_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
      lvl      <= lvl_next;
    end
  end

  always_ff @(posedge clk) begin
    xr       <= xr_next;
    yr       <= yr_next;
    gap      <= gap_next;
    liftx    <= liftx_next;
    ancestor <= ancestor_next;
  end

  // A result comes only from one of the two output steps
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(pc) == S_OUTT || $past(pc) == S_OUTX))
    else $error("result strobe without an output step");

  // The strobe always falls again right after it rises
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // The level counter never runs past one beyond the top level
  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    lvl <= lvl_t'(LEVELS))
    else $error("level counter out of range");

  // Reset always restarts the clearing pass from the first entry
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> (pc == S_CLEAR && clr_addr == '0 && busy))
    else $error("reset did not restart the clearing pass");

endmodule

`default_nettype wire

FILE: hdl/blca_store.sv
`default_nettype none

module blca_store import blca_pkg::*; (
  input  wire logic       clk,
  input  wire store_req_t req,
  output      node_t      tbl_qa,
  output      node_t      tbl_qb,
  output      depth_t     dep_qa,
  output      depth_t     dep_qb
);

  node_t  tbl [TBL_DEPTH];
  depth_t dep [NODES];

  taddr_t tbl_waddr;
  node_t  tbl_wdata;
  logic   tbl_we;
  node_t  dep_waddr;
  depth_t dep_wdata;
  logic   dep_we;

  always_comb begin
    tbl_we    = req.clr | req.tbl_we;
    tbl_waddr = req.clr ? req.clr_addr : tbl_addr(req.tbl_w_node, req.tbl_w_lvl);
    tbl_wdata = req.clr ? '0 : req.tbl_w_data;
    dep_we    = req.clr ? (req.clr_addr < taddr_t'(NODES)) : req.dep_we;
    dep_waddr = req.clr ? req.clr_addr[NODE_W-1:0] : req.dep_w_node;
    dep_wdata = req.clr ? '0 : req.dep_w_data;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_waddr] <= tbl_wdata;
    end
    tbl_qa <= tbl[tbl_addr(req.tbl_ra_node, req.tbl_ra_lvl)];
    tbl_qb <= tbl[tbl_addr(req.tbl_rb_node, req.tbl_rb_lvl)];
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep[dep_waddr] <= dep_wdata;
    end
    dep_qa <= dep[req.dep_ra_node];
    dep_qb <= dep[req.dep_rb_node];
  end

endmodule

`default_nettype wire
